// File: rtl/rv64_integer_alu_assert.svh
// ----------------------------------------------------------------------------
// rv64_integer_alu_assert.svh
// Assertion macros for the integer ALU, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RV64_INTEGER_ALU_ASSERT_SVH
`define RV64_INTEGER_ALU_ASSERT_SVH

// property must hold at every clock edge out of reset
`define RVA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expression must never be true out of reset
`define RVA_ASSERT_NEVER(lbl, expr, msg) \
    `RVA_ASSERT(lbl, !(expr), msg)

`endif

// File: rtl/rv64alu_pkg.sv
// ----------------------------------------------------------------------------
// rv64alu_pkg
// Operation codes and fixed widths of the RV64 integer ALU.
// ----------------------------------------------------------------------------
package rv64alu_pkg;

    // port widths of the request and result fields
    localparam int unsigned XLEN_W  = 64;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned SHAMT_W = 6;

    // operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_XOR  = 4'd2,
        CMD_OR   = 4'd3,
        CMD_AND  = 4'd4,
        CMD_SLL  = 4'd5,
        CMD_SRL  = 4'd6,
        CMD_SRA  = 4'd7,
        CMD_SLT  = 4'd8,
        CMD_SLTU = 4'd9,
        CMD_EQ   = 4'd10,
        CMD_NE   = 4'd11,
        CMD_LT   = 4'd12,
        CMD_GE   = 4'd13,
        CMD_LTU  = 4'd14,
        CMD_GEU  = 4'd15
    } t_alu_cmd;

endpackage

// File: rtl/rv64_integer_alu.sv
// ----------------------------------------------------------------------------
// rv64_integer_alu
// Pipelined RV64 integer ALU: arithmetic, logic, shifts, set-less-than and
// branch compares.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with i_start high; o_busy is always
// low, so one request per cycle is sustained. The result shows on o_result
// with o_done for a single cycle, after passing through each register stage, in
// request order; the receiver has no way to hold it off. The four register
// stages are input capture, low half of the adder plus coarse byte shift,
// high half of the adder plus fine bit shift and compare, and the result
// select. Result bits at and above DATA_WIDTH read zero.
module rv64_integer_alu #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rv64alu_pkg::CMD_W-1:0]     i_command,
    input  logic [rv64alu_pkg::XLEN_W-1:0]    i_operand_a,
    input  logic [rv64alu_pkg::XLEN_W-1:0]    i_operand_b,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [rv64alu_pkg::XLEN_W-1:0]    o_result
);
    import rv64alu_pkg::*;

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned LO = W / 2;
    localparam int unsigned HI = W - LO;

    // ------------------------------------------------------------------
    // Stage 1: capture request, drop operand bits above the width
    // ------------------------------------------------------------------
    logic                r_s1_vld;
    t_alu_cmd            r_s1_cmd;
    logic [W-1:0]        r_s1_a;
    logic [W-1:0]        r_s1_b;
    logic [SHAMT_W-1:0]  r_s1_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
        end
        r_s1_cmd <= t_alu_cmd'(i_command);
        r_s1_a   <= i_operand_a[W-1:0];
        r_s1_b   <= i_operand_b[W-1:0];
        r_s1_sh  <= i_operand_b[SHAMT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: low adder half, logic ops, equality, coarse shift
    // ------------------------------------------------------------------
    logic            n_s2_sub;
    logic [W-1:0]    n_s2_bx;
    logic [LO:0]     n_s2_lo;
    logic [W-1:0]    n_s2_logic;
    logic            n_s2_sll;
    logic            n_s2_fill;
    logic            n_s2_over;
    logic [W-1:0]    n_s2_src;
    logic [2*W-1:0]  n_s2_wide;
    logic [W-1:0]    n_s2_part;

    always_comb begin
        // subtract for sub and all compares
        n_s2_sub = (r_s1_cmd != CMD_ADD);
        n_s2_bx  = n_s2_sub ? ~r_s1_b : r_s1_b;
        n_s2_lo  = {1'b0, r_s1_a[LO-1:0]} + {1'b0, n_s2_bx[LO-1:0]}
                 + (LO+1)'(n_s2_sub);

        case (r_s1_cmd)
            CMD_XOR: n_s2_logic = r_s1_a ^ r_s1_b;
            CMD_OR:  n_s2_logic = r_s1_a | r_s1_b;
            CMD_AND: n_s2_logic = r_s1_a & r_s1_b;
            default: n_s2_logic = r_s1_a & r_s1_b;
        endcase

        // left shift runs through the right shifter on a reversed word
        n_s2_sll  = (r_s1_cmd == CMD_SLL);
        n_s2_fill = (r_s1_cmd == CMD_SRA) && r_s1_a[W-1];
        n_s2_over = ({1'b0, r_s1_sh} >= (SHAMT_W+1)'(W));
        for (int i = 0; i < W; i++) begin
            n_s2_src[i] = n_s2_sll ? r_s1_a[W-1-i] : r_s1_a[i];
        end
        n_s2_wide = {{W{n_s2_fill}}, n_s2_src} >> {r_s1_sh[SHAMT_W-1:3], 3'b000};
        n_s2_part = n_s2_wide[W-1:0];
    end

    logic            r_s2_vld;
    t_alu_cmd        r_s2_cmd;
    logic [HI-1:0]   r_s2_a_hi;
    logic [HI-1:0]   r_s2_bx_hi;
    logic            r_s2_c_lo;
    logic [LO-1:0]   r_s2_sum_lo;
    logic [W-1:0]    r_s2_logic;
    logic            r_s2_eq;
    logic [W-1:0]    r_s2_part;
    logic [2:0]      r_s2_fine;
    logic            r_s2_fill;
    logic            r_s2_over;
    logic            r_s2_sll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_cmd    <= r_s1_cmd;
        r_s2_a_hi   <= r_s1_a[W-1:LO];
        r_s2_bx_hi  <= n_s2_bx[W-1:LO];
        r_s2_c_lo   <= n_s2_lo[LO];
        r_s2_sum_lo <= n_s2_lo[LO-1:0];
        r_s2_logic  <= n_s2_logic;
        r_s2_eq     <= (r_s1_a == r_s1_b);
        r_s2_part   <= n_s2_part;
        r_s2_fine   <= r_s1_sh[2:0];
        r_s2_fill   <= n_s2_fill;
        r_s2_over   <= n_s2_over;
        r_s2_sll    <= n_s2_sll;
    end

    // ------------------------------------------------------------------
    // Stage 3: high adder half, compares, fine shift
    // ------------------------------------------------------------------
    logic [HI:0]     n_s3_hi;
    logic            n_s3_ltu;
    logic            n_s3_lts;
    logic [2*W-1:0]  n_s3_wide;
    logic [W-1:0]    n_s3_rs;
    logic [W-1:0]    n_s3_shres;

    always_comb begin
        n_s3_hi  = {1'b0, r_s2_a_hi} + {1'b0, r_s2_bx_hi} + (HI+1)'(r_s2_c_lo);
        // no carry out of a + ~b + 1 means a < b
        n_s3_ltu = !n_s3_hi[HI];
        n_s3_lts = (r_s2_a_hi[HI-1] != ~r_s2_bx_hi[HI-1]) ? r_s2_a_hi[HI-1]
                                                          : n_s3_ltu;

        n_s3_wide = {{W{r_s2_fill}}, r_s2_part} >> r_s2_fine;
        n_s3_rs   = r_s2_over ? {W{r_s2_fill}} : n_s3_wide[W-1:0];
        for (int i = 0; i < W; i++) begin
            n_s3_shres[i] = r_s2_sll ? n_s3_rs[W-1-i] : n_s3_rs[i];
        end
    end

    logic            r_s3_vld;
    t_alu_cmd        r_s3_cmd;
    logic [W-1:0]    r_s3_sum;
    logic [W-1:0]    r_s3_logic;
    logic [W-1:0]    r_s3_shres;
    logic            r_s3_eq;
    logic            r_s3_ltu;
    logic            r_s3_lts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_cmd   <= r_s2_cmd;
        r_s3_sum   <= {n_s3_hi[HI-1:0], r_s2_sum_lo};
        r_s3_logic <= r_s2_logic;
        r_s3_shres <= n_s3_shres;
        r_s3_eq    <= r_s2_eq;
        r_s3_ltu   <= n_s3_ltu;
        r_s3_lts   <= n_s3_lts;
    end

    // ------------------------------------------------------------------
    // Stage 4: result select into the output register
    // ------------------------------------------------------------------
    logic [W-1:0] n_sel;

    always_comb begin
        case (r_s3_cmd) inside
            CMD_ADD, CMD_SUB:          n_sel = r_s3_sum;
            CMD_XOR, CMD_OR, CMD_AND:  n_sel = r_s3_logic;
            CMD_SLL, CMD_SRL, CMD_SRA: n_sel = r_s3_shres;
            CMD_SLT, CMD_LT:           n_sel = W'(r_s3_lts);
            CMD_SLTU, CMD_LTU:         n_sel = W'(r_s3_ltu);
            CMD_EQ:                    n_sel = W'(r_s3_eq);
            CMD_NE:                    n_sel = W'(!r_s3_eq);
            CMD_GE:                    n_sel = W'(!r_s3_lts);
            CMD_GEU:                   n_sel = W'(!r_s3_ltu);
            default:                   n_sel = r_s3_sum;
        endcase
    end

    logic                r_done;
    logic [XLEN_W-1:0]   r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s3_vld;
        end
        r_result <= XLEN_W'(n_sel);
    end

    assign o_busy   = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "rv64_integer_alu_assert.svh"

    `RVA_ASSERT(a_latency, i_start && !o_busy |-> ##4 o_done, "request lost in pipeline")
    `RVA_ASSERT(a_no_spurious, !(i_start && !o_busy) |-> ##4 !o_done, "result without request")
    `RVA_ASSERT(a_cmp_bool, o_done && ($past(i_command, 4) >= CMD_SLT) |-> (o_result[XLEN_W-1:1] == '0), "compare result not 0 or 1")
    `RVA_ASSERT_NEVER(a_never_busy, o_busy, "busy raised")

endmodule

// File: test/rv64_integer_alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64_integer_alu_checker
// Watches the request and result ports of the integer ALU. Every accepted
// request is run through an ALU model and its expected result is queued. Each
// o_done strobe is compared against the oldest queued result, in order.
// ----------------------------------------------------------------------------
module rv64_integer_alu_checker #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [rv64alu_pkg::CMD_W-1:0]     i_command,
    input  logic [rv64alu_pkg::XLEN_W-1:0]    i_operand_a,
    input  logic [rv64alu_pkg::XLEN_W-1:0]    i_operand_b,
    input  logic                              i_done,
    input  logic [rv64alu_pkg::XLEN_W-1:0]    i_result,
    output int                                o_fail_count,
    output int                                o_pending
);
    import rv64alu_pkg::*;

    typedef logic [XLEN_W-1:0] t_word;

    // results still owed by the ALU, oldest first
    t_word alu_results_due[$];
    int    mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = alu_results_due.size();

    // one line per mismatch, then count it
    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $realtime, what);
        mismatches++;
    endtask

    // ALU model: operands cut to DATA_WIDTH, shift amount is always b[5:0]
    function automatic t_word alu_expected(input t_alu_cmd cmd, input t_word a_in,
                                           input t_word b_in);
        t_word      width_mask;
        t_word      sign_bit;
        t_word      a;
        t_word      b;
        t_word      a_sext;
        t_word      r;
        logic [5:0] shamt;
        logic       lt_signed;
        logic       lt_unsigned;
        width_mask  = {XLEN_W{1'b1}} >> (XLEN_W - DATA_WIDTH);
        sign_bit    = t_word'(1) << (DATA_WIDTH - 1);
        a           = a_in & width_mask;
        b           = b_in & width_mask;
        shamt       = b_in[SHAMT_W-1:0];
        lt_signed   = (a ^ sign_bit) < (b ^ sign_bit);
        lt_unsigned = a < b;
        // sign-extend a to the full 64 bits so >>> fills from the right bit
        a_sext      = (a & sign_bit) != '0 ? (a | ~width_mask) : a;
        case (cmd)
            CMD_ADD:  r = a + b;
            CMD_SUB:  r = a - b;
            CMD_XOR:  r = a ^ b;
            CMD_OR:   r = a | b;
            CMD_AND:  r = a & b;
            CMD_SLL:  r = (shamt >= DATA_WIDTH) ? '0 : (a << shamt);
            CMD_SRL:  r = (shamt >= DATA_WIDTH) ? '0 : (a >> shamt);
            CMD_SRA:  r = $signed(a_sext) >>> shamt;
            CMD_SLT:  r = t_word'(lt_signed);
            CMD_SLTU: r = t_word'(lt_unsigned);
            CMD_EQ:   r = t_word'(a == b);
            CMD_NE:   r = t_word'(a != b);
            CMD_LT:   r = t_word'(lt_signed);
            CMD_GE:   r = t_word'(!lt_signed);
            CMD_LTU:  r = t_word'(lt_unsigned);
            default:  r = t_word'(!lt_unsigned);
        endcase
        return r & width_mask;
    endfunction

    // queue on accept, compare on strobe
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                alu_results_due.push_back(alu_expected(t_alu_cmd'(i_command),
                                                       i_operand_a, i_operand_b));
            if (i_done) begin
                if (alu_results_due.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request outstanding",
                                              i_result));
                end else begin
                    want = alu_results_due.pop_front();
                    if (i_result !== want)
                        report_mismatch($sformatf("result %h, expected %h",
                                                  i_result, want));
                end
            end
        end
    end

endmodule

// File: test/tb_rv64_integer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv64_integer_alu
// Drives the integer ALU with a directed set of corner requests covering every
// operation, then random requests with random idle gaps. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rv64_integer_alu;
    import rv64alu_pkg::*;

    localparam int unsigned ALU_WIDTH      = 64;
    localparam int          RANDOM_COUNT   = 800;
    localparam int          STALL_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEGATIVE  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POSITIVE  = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic [CMD_W-1:0]     i_command;
    logic [XLEN_W-1:0]    i_operand_a;
    logic [XLEN_W-1:0]    i_operand_b;
    logic                 o_busy;
    logic                 o_done;
    logic [XLEN_W-1:0]    o_result;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles;
    bit                   idle_allowed;

    rv64_integer_alu #(
        .DATA_WIDTH (ALU_WIDTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_command   (i_command),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    rv64_integer_alu_checker #(
        .DATA_WIDTH (ALU_WIDTH)
    ) u_alu_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_command    (i_command),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // stall watchdog: too long without an accepted request or a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request, entered and left on a falling edge; each cycle may idle first
    task automatic send_request(input t_alu_cmd cmd, input logic [63:0] a,
                                input logic [63:0] b);
        while (idle_allowed && $urandom_range(0, 99) < 22) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start     <= 1'b1;
        i_command   <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // operand mix: boundary values four times in ten, a small value once in ten, full random otherwise
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return MOST_NEGATIVE;
            3:       return MOST_POSITIVE;
            4:       return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [63:0] a;
        logic [63:0] b;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_command    = '0;
        i_operand_a  = '0;
        i_operand_b  = '0;
        idle_allowed = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: wraparound, every operation, shift extremes, sign boundary
        send_request(CMD_ADD,  ALL_ONES,      64'd1);
        send_request(CMD_SUB,  64'd0,         64'd1);
        send_request(CMD_XOR,  ALL_ONES,      64'h5555_5555_5555_5555);
        send_request(CMD_OR,   64'd0,         64'd0);
        send_request(CMD_AND,  ALL_ONES,      ALL_ONES);
        send_request(CMD_SLL,  64'd1,         64'd63);
        send_request(CMD_SLL,  ALL_ONES,      64'hFFFF_FFFF_FFFF_FFC0);
        send_request(CMD_SRL,  MOST_NEGATIVE, 64'd63);
        send_request(CMD_SRL,  ALL_ONES,      64'd1);
        send_request(CMD_SRA,  MOST_NEGATIVE, 64'd63);
        send_request(CMD_SRA,  MOST_POSITIVE, ALL_ONES);
        send_request(CMD_SRA,  ALL_ONES,      64'h0000_0000_0000_0104);
        send_request(CMD_SLT,  MOST_NEGATIVE, 64'd0);
        send_request(CMD_SLT,  MOST_POSITIVE, MOST_POSITIVE);
        send_request(CMD_SLTU, MOST_NEGATIVE, 64'd0);
        send_request(CMD_EQ,   ALL_ONES,      ALL_ONES);
        send_request(CMD_NE,   ALL_ONES,      ALL_ONES);
        send_request(CMD_LT,   MOST_POSITIVE, MOST_NEGATIVE);
        send_request(CMD_GE,   MOST_NEGATIVE, MOST_NEGATIVE);
        send_request(CMD_GE,   MOST_NEGATIVE, MOST_POSITIVE);
        send_request(CMD_LTU,  64'd0,         ALL_ONES);
        send_request(CMD_GEU,  ALL_ONES,      ALL_ONES);
        send_request(CMD_GEU,  64'd0,         64'd1);

        // random requests; a back-to-back stretch in the middle
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            idle_allowed = (n < 300 || n >= 500);
            a = pick_operand();
            case ($urandom_range(0, 9))
                0:       b = a;
                1:       b = a ^ 64'(1) << $urandom_range(0, 63);
                default: b = pick_operand();
            endcase
            send_request(t_alu_cmd'($urandom_range(0, 15)), a, b);
        end
        i_start <= 1'b0;

        // drain, then let the pipeline settle
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rv64alu_pkg.sv
rtl/rv64_integer_alu.sv
test/rv64_integer_alu_checker.sv
test/tb_rv64_integer_alu.sv
